[design/boae_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bounded ordered array engine.
// No dependencies; imported by the front, back and top-level modules.
package boae_pkg;

	// Field widths fixed by the stream format
	localparam int REQ_W   = 3;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int FILL_W  = 7;

	// Capacity register reset value
	localparam logic [FILL_W-1:0] CAP_RESET = 7'd64;

	// Request codes as they arrive on the input stream
	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND  = 3'd0,
		REQ_INSERT  = 3'd1,
		REQ_GET     = 3'd2,
		REQ_REPLACE = 3'd3,
		REQ_REMOVE  = 3'd4,
		REQ_POP     = 3'd5
	} req_code_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Classified request handed from the front queue to the back end
	typedef struct packed {
		logic              known;
		req_code_t         code;
		logic [POS_W-1:0]  pos;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	// Result word held in the output register
	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   elem;
		logic [FILL_W-1:0]  count;
	} res_t;

endpackage

[design/bounded_ordered_array_engine_core.sv]
`timescale 1ns / 1ps
// Top level of the bounded ordered array engine.
// Depends on boae_pkg, boae_front, boae_back (and boae_ram below it).
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the request code
//   (append, insert, get, replace, remove, pop), s_tdata the position and
//   the element value. Every request produces exactly one result word on
//   the m_ stream: status in m_tuser, element and count in m_tdata.
//   cfg_we/cfg_wdata write the usable capacity; write only while idle.
//   Flow: append, unknown codes and rejected requests complete in the idle
//   state of the back end; get, replace and pop pass through a read state;
//   insert before the end shifts later entries up and then writes the new
//   one, remove reads the element and shifts later entries down, one entry
//   moved per cycle through the single write port of the element RAM. The
//   front queue registers each word ahead of that. The back end handles one request at a time.
//   A two-word queue in front accepts new words while the back end works.
//   If the receiver holds m_tready low, the result stays in the output
//   register and the back end waits; the queue fills and s_tready drops.
//   Reset empties the array and the queue and sets the capacity to 64;
//   RAM contents are not cleared, as only written entries are ever read.
module bounded_ordered_array_engine_core #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,   // [6:0] capacity_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,     // [6:0] position, [38:7] item_value
	input  logic [2:0]  s_tuser,     // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,     // [31:0] element_out, [38:32] count
	output logic [1:0]  m_tuser      // [1:0] status
);
	import boae_pkg::*;

	cmd_t q_cmd;
	logic q_valid;
	logic q_ready;
	res_t res;

	boae_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	boae_back #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result word
	assign m_tdata = {1'b0, res.count, res.elem};
	assign m_tuser = res.status;

endmodule

[design/boae_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module boae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/boae_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request words, classifies the request code and
// queues classified commands for the back end. Depends on boae_pkg.
module boae_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [39:0]    s_tdata,   // [6:0] position, [38:7] item_value
	input  logic [2:0]     s_tuser,   // [2:0] req_type
	output logic           q_valid,
	input  logic           q_ready,
	output boae_pkg::cmd_t q_cmd
);
	import boae_pkg::*;

	localparam int POS_LSB = 0;
	localparam int VAL_LSB = POS_LSB + POS_W;

	cmd_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       in_cmd;
	logic       push;
	logic       pop;

	// Classify the incoming request
	always_comb begin
		in_cmd.known = (s_tuser <= REQ_POP);
		in_cmd.code  = in_cmd.known ? req_code_t'(s_tuser) : REQ_APPEND;
		in_cmd.pos   = s_tdata[POS_LSB +: POS_W];
		in_cmd.value = s_tdata[VAL_LSB +: VAL_W];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = buf_q[rd_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	// Two-entry command queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_cmd;
		end
	end

	// Queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/boae_back.sv]
`timescale 1ns / 1ps
// Back end: executes queued commands against the element RAM, shifts
// entries for insert/remove and holds the result word. Depends on boae_pkg, boae_ram.
module boae_back #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [boae_pkg::FILL_W-1:0]   cfg_wdata,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  boae_pkg::cmd_t                q_cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output boae_pkg::res_t                res
);
	import boae_pkg::*;

	localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CAP_LIM = (CAPACITY > 127) ? 127 : CAPACITY;
	localparam logic [FILL_W-1:0] CAP_LIM_V = FILL_W'(CAP_LIM);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_READ    = 6'b000010,
		S_DN_ELEM = 6'b000100,
		S_DN_MOVE = 6'b001000,
		S_UP_MOVE = 6'b010000,
		S_UP_FIN  = 6'b100000
	} state_t;

	state_t                  state_q, state_d;
	logic [FILL_W-1:0]       cap_q;
	logic [FILL_W-1:0]       fill_q, fill_d;
	logic [FILL_W-1:0]       ptr_q, ptr_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic [ELEM_WIDTH-1:0]   val_q, val_d;
	logic [ELEM_WIDTH-1:0]   elem_q, elem_d;
	logic                    res_valid_q, res_valid_d;
	res_t                    res_q, res_d;

	logic                    ram_we;
	logic [FILL_W-1:0]       ram_widx;
	logic [ELEM_WIDTH-1:0]   ram_wdata;
	logic [FILL_W-1:0]       ram_ridx;
	logic [ELEM_WIDTH-1:0]   ram_rdata;

	logic [FILL_W-1:0]       cap;
	logic                    full;
	logic                    out_free;
	logic [FILL_W:0]         ptr_p2;
	logic [FILL_W:0]         pos_p1;
	logic [FILL_W-1:0]       ptr_m1;

	boae_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(ram_widx)),
		.wdata (ram_wdata),
		.raddr (AW'(ram_ridx)),
		.rdata (ram_rdata)
	);

	// Usable capacity and index arithmetic
	assign cap      = (cap_q < CAP_LIM_V) ? cap_q : CAP_LIM_V;
	assign full     = (fill_q >= cap);
	assign out_free = !res_valid_q || res_ready;
	assign ptr_p2   = {1'b0, ptr_q} + (FILL_W+1)'(2);
	assign pos_p1   = {1'b0, pos_q} + (FILL_W+1)'(1);
	assign ptr_m1   = ptr_q - FILL_W'(1);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Sequencer: checks, single accesses and one-entry-per-cycle shifts
	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		ptr_d       = ptr_q;
		pos_d       = pos_q;
		val_d       = val_q;
		elem_d      = elem_q;
		res_valid_d = res_valid_q && !res_ready;
		res_d       = res_q;
		ram_we      = 1'b0;
		ram_widx    = fill_q;
		ram_wdata   = val_q;
		ram_ridx    = '0;
		q_ready     = 1'b0;

		case (state_q)
			S_IDLE: begin
				q_ready = out_free;
				if (q_valid && out_free) begin
					pos_d        = q_cmd.pos;
					val_d        = ELEM_WIDTH'(q_cmd.value);
					res_d.status = ST_OK;
					res_d.elem   = '0;
					res_d.count  = fill_q;
					if (!q_cmd.known) begin
						res_valid_d = 1'b1;
					end else begin
						case (q_cmd.code)
							REQ_APPEND: begin
								res_valid_d = 1'b1;
								if (full) begin
									res_d.status = ST_FULL;
								end else begin
									ram_we      = 1'b1;
									ram_widx    = fill_q;
									ram_wdata   = ELEM_WIDTH'(q_cmd.value);
									fill_d      = fill_q + FILL_W'(1);
									res_d.count = fill_q + FILL_W'(1);
								end
							end
							REQ_INSERT: begin
								if (q_cmd.pos > fill_q) begin
									res_valid_d  = 1'b1;
									res_d.status = ST_RANGE;
								end else if (full) begin
									res_valid_d  = 1'b1;
									res_d.status = ST_FULL;
								end else if (q_cmd.pos == fill_q) begin
									res_valid_d = 1'b1;
									ram_we      = 1'b1;
									ram_widx    = q_cmd.pos;
									ram_wdata   = ELEM_WIDTH'(q_cmd.value);
									fill_d      = fill_q + FILL_W'(1);
									res_d.count = fill_q + FILL_W'(1);
								end else begin
									ptr_d    = fill_q;
									ram_ridx = fill_q - FILL_W'(1);
									state_d  = S_UP_MOVE;
								end
							end
							REQ_GET: begin
								if (q_cmd.pos >= fill_q) begin
									res_valid_d  = 1'b1;
									res_d.status = ST_RANGE;
								end else begin
									ram_ridx = q_cmd.pos;
									state_d  = S_READ;
								end
							end
							REQ_REPLACE: begin
								if (q_cmd.pos >= fill_q) begin
									res_valid_d  = 1'b1;
									res_d.status = ST_RANGE;
								end else begin
									// read returns the old value on this same edge
									ram_ridx  = q_cmd.pos;
									ram_we    = 1'b1;
									ram_widx  = q_cmd.pos;
									ram_wdata = ELEM_WIDTH'(q_cmd.value);
									state_d   = S_READ;
								end
							end
							REQ_REMOVE: begin
								if (q_cmd.pos >= fill_q) begin
									res_valid_d  = 1'b1;
									res_d.status = ST_RANGE;
								end else begin
									ram_ridx = q_cmd.pos;
									state_d  = S_DN_ELEM;
								end
							end
							REQ_POP: begin
								if (fill_q == '0) begin
									res_valid_d  = 1'b1;
									res_d.status = ST_RANGE;
								end else begin
									fill_d   = fill_q - FILL_W'(1);
									ram_ridx = fill_q - FILL_W'(1);
									state_d  = S_READ;
								end
							end
							default: begin
								res_valid_d = 1'b1;
							end
						endcase
					end
				end
			end

			// Single read completes: get, replace, pop
			S_READ: begin
				res_valid_d  = 1'b1;
				res_d.status = ST_OK;
				res_d.elem   = VAL_W'(ram_rdata);
				res_d.count  = fill_q;
				state_d      = S_IDLE;
			end

			// Removed element arrives; start moving later entries down, or finish if it was the last
			S_DN_ELEM: begin
				elem_d = ram_rdata;
				if (pos_p1 < {1'b0, fill_q}) begin
					ptr_d    = pos_q;
					ram_ridx = FILL_W'(pos_p1);
					state_d  = S_DN_MOVE;
				end else begin
					fill_d       = fill_q - FILL_W'(1);
					res_valid_d  = 1'b1;
					res_d.status = ST_OK;
					res_d.elem   = VAL_W'(ram_rdata);
					res_d.count  = fill_q - FILL_W'(1);
					state_d      = S_IDLE;
				end
			end

			// slots[ptr] <= slots[ptr+1], next read two ahead
			S_DN_MOVE: begin
				ram_we    = 1'b1;
				ram_widx  = ptr_q;
				ram_wdata = ram_rdata;
				ptr_d     = ptr_q + FILL_W'(1);
				if (ptr_p2 < {1'b0, fill_q}) begin
					ram_ridx = FILL_W'(ptr_p2);
				end else begin
					fill_d       = fill_q - FILL_W'(1);
					res_valid_d  = 1'b1;
					res_d.status = ST_OK;
					res_d.elem   = VAL_W'(elem_q);
					res_d.count  = fill_q - FILL_W'(1);
					state_d      = S_IDLE;
				end
			end

			// slots[ptr] <= slots[ptr-1], walking down to the insert point
			S_UP_MOVE: begin
				ram_we    = 1'b1;
				ram_widx  = ptr_q;
				ram_wdata = ram_rdata;
				if (ptr_m1 > FILL_W'(pos_q)) begin
					ram_ridx = ptr_q - FILL_W'(2);
					ptr_d    = ptr_m1;
				end else begin
					state_d = S_UP_FIN;
				end
			end

			// Drop the new element into the opened slot
			S_UP_FIN: begin
				ram_we       = 1'b1;
				ram_widx     = FILL_W'(pos_q);
				ram_wdata    = val_q;
				fill_d       = fill_q + FILL_W'(1);
				res_valid_d  = 1'b1;
				res_d.status = ST_OK;
				res_d.elem   = '0;
				res_d.count  = fill_q + FILL_W'(1);
				state_d      = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			res_valid_q <= res_valid_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		pos_q  <= pos_d;
		val_q  <= val_d;
		elem_q <= elem_d;
		res_q  <= res_d;
	end

endmodule

[tb/sv/boae_outcome_checker.sv]
`timescale 1ns / 1ps
// Result checker for the bounded ordered array engine: keeps a shadow array,
// predicts one result word per accepted request and compares. Depends on boae_pkg.
module boae_outcome_checker #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,     // [6:0] position, [38:7] item_value
	input  logic [2:0]  s_tuser,     // [2:0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,     // [31:0] element_out, [38:32] count
	input  logic [1:0]  m_tuser,     // [1:0] status
	output int          mismatches,
	output int          awaiting
);
	import boae_pkg::*;

	// Shadow copy of the array, its fill level and the capacity register
	logic [VAL_W-1:0]  shadow [SLOTS];
	int                level;
	logic [FILL_W-1:0] cap_reg;
	res_t              expected_words [$];
	res_t              want;
	int                bad_cnt;

	// Apply one request to the shadow array; return the word it must produce
	function automatic res_t predict_outcome(input logic [REQ_W-1:0] code,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		res_t r;
		int   lim;
		int   k;
		r.status = ST_OK;
		r.elem   = '0;
		lim = (int'(cap_reg) < SLOTS) ? int'(cap_reg) : SLOTS;
		case (code)
			REQ_APPEND: begin
				if (level >= lim) begin
					r.status = ST_FULL;
				end else begin
					shadow[level] = val;
					level++;
				end
			end
			REQ_INSERT: begin
				// range check wins over the full check
				if (int'(pos) > level) begin
					r.status = ST_RANGE;
				end else if (level >= lim) begin
					r.status = ST_FULL;
				end else begin
					for (k = level; k > int'(pos); k--)
						shadow[k] = shadow[k-1];
					shadow[pos] = val;
					level++;
				end
			end
			REQ_GET: begin
				if (int'(pos) >= level)
					r.status = ST_RANGE;
				else
					r.elem = shadow[pos];
			end
			REQ_REPLACE: begin
				if (int'(pos) >= level) begin
					r.status = ST_RANGE;
				end else begin
					r.elem      = shadow[pos];
					shadow[pos] = val;
				end
			end
			REQ_REMOVE: begin
				if (int'(pos) >= level) begin
					r.status = ST_RANGE;
				end else begin
					r.elem = shadow[pos];
					for (k = int'(pos); k + 1 < level; k++)
						shadow[k] = shadow[k+1];
					level--;
				end
			end
			REQ_POP: begin
				if (level == 0) begin
					r.status = ST_RANGE;
				end else begin
					level--;
					r.elem = shadow[level];
				end
			end
			default: ;  // unknown codes leave everything alone
		endcase
		r.count = FILL_W'(level);
		return r;
	endfunction

	// Track config writes, check results, queue predictions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level   = 0;
			cap_reg = CAP_RESET;
			bad_cnt = 0;
			expected_words.delete();
		end else begin
			if (cfg_we)
				cap_reg = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					if (bad_cnt < 10)
						$display("%t: result word with nothing pending: ", $time,
							"status %0d elem %h count %0d",
							m_tuser, m_tdata[31:0], m_tdata[38:32]);
					bad_cnt++;
				end else begin
					want = expected_words.pop_front();
					if (m_tuser !== want.status || m_tdata[31:0] !== want.elem ||
							m_tdata[38:32] !== want.count) begin
						if (bad_cnt < 10)
							$display("%t: result mismatch: ", $time,
								"expected status %0d elem %h count %0d, ",
								want.status, want.elem, want.count,
								"got status %0d elem %h count %0d",
								m_tuser, m_tdata[31:0], m_tdata[38:32]);
						bad_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(
					predict_outcome(s_tuser, s_tdata[6:0], s_tdata[38:7]));
		end
		mismatches <= bad_cnt;
		awaiting   <= expected_words.size();
	end

endmodule

[tb/sv/bounded_ordered_array_engine_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for bounded_ordered_array_engine_core: drives requests and capacity writes,
// throttles the result side. Depends on boae_pkg, boae_outcome_checker and the core.
module bounded_ordered_array_engine_core_tb;
	import boae_pkg::*;

	localparam int SLOTS        = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 220;
	// request codes the block does not define
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

	typedef enum int {LEAN_GROW, LEAN_EVEN, LEAN_SHRINK} lean_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;     // [6:0] position, [38:7] item_value
	logic [2:0]  s_tuser;     // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;     // [31:0] element_out, [38:32] count
	logic [1:0]  m_tuser;     // [1:0] status
	int          mismatches;
	int          awaiting;

	int          lvl;         // rough fill level, only to aim positions
	int          cur_cap;
	int          burst_left;
	int          hold_asks;
	int          cycle_cnt;
	bit          valid_hi;

	bounded_ordered_array_engine_core #(
		.CAPACITY   (SLOTS),
		.ELEM_WIDTH (32)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	boae_outcome_checker #(
		.SLOTS (SLOTS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one request word and hold it until taken; then maybe end the burst
	task automatic push_word(input logic [REQ_W-1:0] code, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		int lim;
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= {1'b0, val, pos};
		valid_hi = 1'b1;
		do @(posedge clk); while (!s_tready);
		lim = (cur_cap < SLOTS) ? cur_cap : SLOTS;
		case (code)
			REQ_APPEND: if (lvl < lim) lvl++;
			REQ_INSERT: if (int'(pos) <= lvl && lvl < lim) lvl++;
			REQ_REMOVE: if (int'(pos) < lvl) lvl--;
			REQ_POP:    if (lvl > 0) lvl--;
			default: ;
		endcase
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			valid_hi = 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
	endtask

	// Stop offering and wait until every pending result word is back
	task automatic drain_results();
		if (valid_hi) begin
			s_tvalid <= 1'b0;
			valid_hi = 1'b0;
		end
		do @(posedge clk); while (awaiting != 0);
	endtask

	// Capacity is only written with the block idle
	task automatic write_capacity(input logic [6:0] cap);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_cap = int'(cap);
	endtask

	// One capacity setting, then random requests with a drifting grow/shrink lean
	task automatic random_phase(input int n_items, input logic [6:0] cap, input bit ask_hold);
		lean_t            lean;
		int               lean_left;
		int               r;
		int               i;
		logic [REQ_W-1:0] code;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		write_capacity(cap);
		if (ask_hold)
			hold_asks <= hold_asks + 1;
		lean      = LEAN_EVEN;
		lean_left = 0;
		for (i = 0; i < n_items; i++) begin
			if (lean_left == 0) begin
				lean      = lean_t'($urandom_range(0, 2));
				lean_left = $urandom_range(30, 150);
			end
			lean_left--;
			r = $urandom_range(0, 99);
			if (r >= 98)
				code = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
			else if (lean == LEAN_GROW)
				code = (r < 40) ? REQ_APPEND : (r < 75) ? REQ_INSERT : (r < 83) ? REQ_GET
					: (r < 90) ? REQ_REPLACE : (r < 95) ? REQ_REMOVE : REQ_POP;
			else if (lean == LEAN_SHRINK)
				code = (r < 3) ? REQ_APPEND : (r < 8) ? REQ_INSERT : (r < 15) ? REQ_GET
					: (r < 23) ? REQ_REPLACE : (r < 63) ? REQ_REMOVE : REQ_POP;
			else
				code = (r < 16) ? REQ_APPEND : (r < 34) ? REQ_INSERT : (r < 50) ? REQ_GET
					: (r < 66) ? REQ_REPLACE : (r < 82) ? REQ_REMOVE : REQ_POP;
			// mostly legal positions, some at the edge, a few anywhere
			r = $urandom_range(0, 99);
			if (r < 80)
				pos = (code == REQ_INSERT) ? POS_W'($urandom_range(0, lvl))
					: ((lvl > 0) ? POS_W'($urandom_range(0, lvl - 1)) : '0);
			else if (r < 90)
				pos = POS_W'(lvl + $urandom_range(0, 1));
			else if (r < 97)
				pos = POS_W'($urandom_range(0, 64));
			else
				pos = POS_W'($urandom_range(0, 127));
			r = $urandom_range(0, 19);
			val = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
			push_word(code, pos, val);
		end
	endtask

	// Result side: random ready patterns plus long hold-offs on request
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		int hold_seen;
		int pct;
		int period;
		int tick;
		bit rdy;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		pct       = 100;
		period    = 1;
		tick      = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = $urandom_range(300, 500);
			end
			rdy = 1'b1;
			if (hold_left == 0) begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 19);
					mode_left = $urandom_range(10, 200);
					pct       = $urandom_range(20, 90);
					period    = $urandom_range(2, 6);
					if (mode == 19)
						hold_left = $urandom_range(50, 200);
				end
				mode_left--;
				tick++;
				if (mode < 6)
					rdy = 1'b1;
				else if (mode < 13)
					rdy = ($urandom_range(0, 99) < pct);
				else
					rdy = (tick % period == 0);
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end
			m_tready <= rdy;
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		valid_hi   = 1'b0;
		lvl        = 0;
		cur_cap    = int'(CAP_RESET);
		burst_left = 5;
		hold_asks  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty array: everything but append/insert at 0 is out of range
		push_word(REQ_POP,     7'd0,   32'h0000_0000);
		push_word(REQ_GET,     7'd0,   32'h0000_0000);
		push_word(REQ_REPLACE, 7'd0,   32'hDEAD_BEEF);
		push_word(REQ_REMOVE,  7'd0,   32'h0000_0000);
		push_word(REQ_INSERT,  7'd1,   32'h1111_1111);
		push_word(REQ_INSERT,  7'd127, 32'hFFFF_FFFF);
		// fill, shift up, read, overwrite, shift down
		push_word(REQ_APPEND,  7'd0,   32'h0000_0000);
		push_word(REQ_APPEND,  7'd127, 32'hFFFF_FFFF);
		push_word(REQ_INSERT,  7'd0,   32'hA5A5_A5A5);
		push_word(REQ_INSERT,  7'd3,   32'h5A5A_5A5A);
		push_word(REQ_GET,     7'd0,   32'h0000_0000);
		push_word(REQ_GET,     7'd3,   32'h0000_0000);
		push_word(REQ_GET,     7'd4,   32'h0000_0000);
		push_word(REQ_REPLACE, 7'd1,   32'h1234_5678);
		push_word(REQ_REMOVE,  7'd1,   32'h0000_0000);
		push_word(REQ_REMOVE,  7'd127, 32'h0000_0000);
		push_word(REQ_POP,     7'd0,   32'h0000_0000);
		push_word(REQ_SPARE_A, 7'd127, 32'hFFFF_FFFF);
		push_word(REQ_SPARE_B, 7'd0,   32'h0000_0000);
		// small capacity: full on append and insert, range check first
		write_capacity(7'd3);
		push_word(REQ_APPEND,  7'd0,   32'h0000_0001);
		push_word(REQ_APPEND,  7'd0,   32'h0000_0002);
		push_word(REQ_INSERT,  7'd5,   32'h0000_0003);
		push_word(REQ_INSERT,  7'd0,   32'h0000_0004);
		// capacity below the fill level: reads and removals still work
		write_capacity(7'd1);
		push_word(REQ_GET,     7'd2,   32'h0000_0000);
		push_word(REQ_APPEND,  7'd0,   32'h0000_0005);
		push_word(REQ_POP,     7'd0,   32'h0000_0000);
		push_word(REQ_REMOVE,  7'd0,   32'h0000_0000);

		// random traffic over several capacity settings
		random_phase(PHASE_ITEMS, 7'd64,  1'b1);
		random_phase(PHASE_ITEMS, 7'd127, 1'b0);
		random_phase(PHASE_ITEMS, 7'd0,   1'b0);
		random_phase(PHASE_ITEMS, 7'd40,  1'b0);
		random_phase(PHASE_ITEMS, 7'd2,   1'b0);
		random_phase(PHASE_ITEMS, 7'd64,  1'b1);
		random_phase(PHASE_ITEMS, 7'd9,   1'b0);

		drain_results();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
